/* design/mlft_pkg.sv */
// ----------------------------------------------------------------------------
// mlft_pkg: shared definitions for the MAC learning forwarding table
// Table sizes, field widths and the word types carried on the channels.
// ----------------------------------------------------------------------------
package mlft_pkg;

  // Table and port sizes.
  localparam int TableDepth = 64;
  localparam int NumPorts   = 8;

  // Field widths, fixed by the frame header and result formats.
  localparam int MacW  = 48;
  localparam int PortW = 3;
  localparam int MaskW = 8;

  // Derived widths: a slot index, and a fill count that can hold the depth itself.
  localparam int IdxW   = $clog2(TableDepth);
  localparam int CntW   = $clog2(TableDepth + 1);
  localparam int EntryW = MacW + PortW;

  // Ports that exist, as a forwarding mask.
  localparam logic [MaskW-1:0] AllPorts = MaskW'((64'd1 << NumPorts) - 64'd1);

  // Frame header word.
  typedef struct packed {
    logic [MacW-1:0]  src_mac;
    logic [MacW-1:0]  dst_mac;
    logic [PortW-1:0] ingress_port;
  } frame_t;

  // Forwarding result word.
  typedef struct packed {
    logic [MaskW-1:0] forward_mask;
    logic             flooded;
    logic             learned;
    logic             learn_dropped;
  } result_t;

  // Configuration word.
  typedef logic [MaskW-1:0] cfg_t;

endpackage

/* design/mlft_if.sv */
// ----------------------------------------------------------------------------
// mlft_if: valid/ready channels of the MAC learning forwarding table
// One interface per word type: frame headers, results and configuration.
// ----------------------------------------------------------------------------

// Frame header channel.
interface mlft_frame_if;
  logic            valid;
  logic            ready;
  mlft_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Forwarding result channel.
interface mlft_result_if;
  logic              valid;
  logic              ready;
  mlft_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel, carrying the port enable mask.
interface mlft_cfg_if;
  logic           valid;
  logic           ready;
  mlft_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/mlft_ram.sv */
// ----------------------------------------------------------------------------
// mlft_ram: generic single-write, single-read RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mlft_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mac_learning_forward_table.sv */
// ----------------------------------------------------------------------------
// mac_learning_forward_table: learning bridge forwarding table
// Learns source addresses against their ingress port and looks up the
// destination address to give a forwarding mask, flooding on a miss.
// ----------------------------------------------------------------------------
//
//  Channel   Role   Word       Notes
//  frame_i   sink   frame_t    source MAC, destination MAC, ingress port
//  result_o  source result_t   forward mask, flooded, learned, learn dropped
//  cfg_i     sink   cfg_t      port enable mask, always ready
//
// A frame is compared with every stored station before its result is given,
// since the table memory has one read port and a single comparator pair checks
// one stored entry a cycle. The next frame is taken the cycle after the result
// is registered, so a frame is never taken while the last one is being scanned.
// Slots fill from the bottom and are never freed, so the fill count stands for
// the valid bits; reset clears it at once and needs no clearing pass.
// A new frame is taken while a result waits; the learning write and the next
// result wait until the output register is free.
module mac_learning_forward_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  mlft_frame_if.sink   frame_i,
  mlft_result_if.source result_o,
  mlft_cfg_if.sink     cfg_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e                        state_q, state_d;
  logic [mlft_pkg::CntW-1:0]     count_q, count_d;
  logic [mlft_pkg::CntW-1:0]     rd_idx_q, rd_idx_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic                          src_hit_q, src_hit_d;
  logic                          dst_hit_q, dst_hit_d;
  logic [mlft_pkg::PortW-1:0]    dst_port_q, dst_port_d;
  mlft_pkg::frame_t              frame_q, frame_d;
  logic [mlft_pkg::MaskW-1:0]    enable_q;
  logic                          out_valid_q, out_valid_d;
  mlft_pkg::result_t             out_data_q, out_data_d;

  logic                          ram_we;
  logic                          ram_re;
  logic [mlft_pkg::EntryW-1:0]   ram_wdata;
  logic [mlft_pkg::EntryW-1:0]   ram_rdata;
  logic [mlft_pkg::MacW-1:0]     rd_mac;
  logic [mlft_pkg::PortW-1:0]    rd_port;
  logic                          out_free;
  logic                          table_full;

  // Station memory: MAC address above the port number.
  mlft_ram #(
    .Width (mlft_pkg::EntryW),
    .Depth (mlft_pkg::TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[mlft_pkg::IdxW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[mlft_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_mac     = ram_rdata[mlft_pkg::EntryW-1:mlft_pkg::PortW];
  assign rd_port    = ram_rdata[mlft_pkg::PortW-1:0];
  assign ram_wdata  = {frame_q.src_mac, frame_q.ingress_port};
  assign out_free   = !out_valid_q || result_o.ready;
  assign table_full = (count_q == mlft_pkg::CntW'(mlft_pkg::TableDepth));

  // Handshakes towards the neighbours.
  assign frame_i.ready  = (state_q == StIdle);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // Sequencer: accept, scan the stored stations, then learn and report.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    src_hit_d   = src_hit_q;
    dst_hit_d   = dst_hit_q;
    dst_port_d  = dst_port_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (frame_i.valid) begin
          frame_d   = frame_i.data;
          rd_idx_d  = '0;
          src_hit_d = 1'b0;
          dst_hit_d = 1'b0;
          state_d   = StScan;
        end
      end
      StScan: begin
        // Issue the next read while the previous one is compared.
        if (rd_idx_q < count_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          rd_idx_d  = rd_idx_q + mlft_pkg::CntW'(1);
        end else if (!cmp_vld_q) begin
          state_d = StFinish;
        end
        if (cmp_vld_q) begin
          if (rd_mac == frame_q.src_mac) begin
            src_hit_d = 1'b1;
          end
          if (!dst_hit_q && rd_mac == frame_q.dst_mac) begin
            dst_hit_d  = 1'b1;
            dst_port_d = rd_port;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          out_data_d.learned       = 1'b0;
          out_data_d.learn_dropped = 1'b0;
          if (!src_hit_q) begin
            if (table_full) begin
              out_data_d.learn_dropped = 1'b1;
            end else begin
              ram_we                 = 1'b1;
              count_d                = count_q + mlft_pkg::CntW'(1);
              out_data_d.learned     = 1'b1;
            end
          end
          // A frame sent to itself hits the station it has just taught.
          if (dst_hit_q) begin
            out_data_d.forward_mask =
              (mlft_pkg::MaskW'(1) << dst_port_q) & mlft_pkg::AllPorts;
            out_data_d.flooded      = 1'b0;
          end else if (ram_we && frame_q.dst_mac == frame_q.src_mac) begin
            out_data_d.forward_mask =
              (mlft_pkg::MaskW'(1) << frame_q.ingress_port) & mlft_pkg::AllPorts;
            out_data_d.flooded      = 1'b0;
          end else begin
            out_data_d.forward_mask = enable_q & mlft_pkg::AllPorts &
                                      ~(mlft_pkg::MaskW'(1) << frame_q.ingress_port);
            out_data_d.flooded      = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State, counters, the frame held under scan, the enable mask and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      src_hit_q   <= 1'b0;
      dst_hit_q   <= 1'b0;
      dst_port_q  <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      enable_q    <= mlft_pkg::MaskW'(8'hFF);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      src_hit_q   <= src_hit_d;
      dst_hit_q   <= dst_hit_d;
      dst_port_q  <= dst_port_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      if (cfg_i.valid) begin
        enable_q <= cfg_i.data;
      end
    end
  end

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mlft_pkg::CntW'(mlft_pkg::TableDepth))
    else $error("fill count beyond table depth");

  // The fill count only ever grows by one, and only with a table write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + mlft_pkg::CntW'(1)) && $past(ram_we))
    else $error("fill count changed without a single learning write");

  // A learning write is followed by a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> out_valid_q && out_data_q.learned)
    else $error("learning write without a learned result");

  // A result never claims both a learn and a dropped learn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.learned && out_data_q.learn_dropped))
    else $error("result both learned and dropped");

  // The scan pointer never runs past the stored stations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> rd_idx_q <= count_q)
    else $error("scan pointer beyond fill count");

endmodule

/* dv/mlft_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlft_checker: forwarding prediction and result comparison
// Watches the frame, configuration and result channels of the MAC learning
// forwarding table. It keeps its own station table and port enable mask,
// works out the result word of every accepted frame word, and compares each
// accepted result word field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mlft_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  mlft_frame_if  frame_mon,
  mlft_result_if result_mon,
  mlft_cfg_if    cfg_mon,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o,
  output int     flooded_o,
  output int     learned_o,
  output int     dropped_o
);

  localparam int             MaxReports = 10;
  localparam mlft_pkg::cfg_t MaskReset  = '1;

  // Predicted station table, filled from the lowest free slot.
  logic                       station_valid [mlft_pkg::TableDepth];
  logic [mlft_pkg::MacW-1:0]  station_mac   [mlft_pkg::TableDepth];
  logic [mlft_pkg::PortW-1:0] station_port  [mlft_pkg::TableDepth];
  int                         station_count;
  mlft_pkg::cfg_t             enable_mask;

  // Result words predicted for accepted frames, oldest first.
  mlft_pkg::result_t          expected_results [$];

  // Returns the lowest valid slot holding the address, or -1 when absent.
  function automatic int lookup_station(logic [mlft_pkg::MacW-1:0] mac);
    int slot;
    slot = -1;
    for (int i = mlft_pkg::TableDepth - 1; i >= 0; i--) begin
      if (station_valid[i] && station_mac[i] == mac) slot = i;
    end
    return slot;
  endfunction

  // Learns the source address, then looks up the destination after learning.
  function automatic mlft_pkg::result_t forward_frame(mlft_pkg::frame_t f);
    mlft_pkg::result_t r;
    int                slot;
    int                free_slot;
    r = '0;
    if (lookup_station(f.src_mac) < 0) begin
      free_slot = -1;
      for (int i = mlft_pkg::TableDepth - 1; i >= 0; i--) begin
        if (!station_valid[i]) free_slot = i;
      end
      if (free_slot >= 0 && station_count < mlft_pkg::TableDepth) begin
        station_valid[free_slot] = 1'b1;
        station_mac[free_slot]   = f.src_mac;
        station_port[free_slot]  = f.ingress_port;
        station_count++;
        r.learned = 1'b1;
      end else begin
        r.learn_dropped = 1'b1;
      end
    end
    slot = lookup_station(f.dst_mac);
    if (slot >= 0) begin
      // A hit goes to the stored port whatever the enable mask says.
      r.forward_mask = (mlft_pkg::MaskW'(1) << station_port[slot]) & mlft_pkg::AllPorts;
    end else begin
      r.forward_mask = enable_mask & ~(mlft_pkg::MaskW'(1) << f.ingress_port) &
                       mlft_pkg::AllPorts;
      r.flooded      = 1'b1;
    end
    return r;
  endfunction

  // Results are compared before the prediction of a frame taken at the same
  // edge is queued, so the order of the queue follows the order of words.
  always @(posedge clk_i or negedge rst_ni) begin
    mlft_pkg::result_t want;
    mlft_pkg::result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < mlft_pkg::TableDepth; i++) station_valid[i] = 1'b0;
      station_count = 0;
      enable_mask   = MaskReset;
      expected_results.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      flooded_o     = 0;
      learned_o     = 0;
      dropped_o     = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got = result_mon.data;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display({"%0t: result word with no frame outstanding: ",
                      "mask %02h flood %b learn %b drop %b"},
                     $realtime, got.forward_mask, got.flooded, got.learned,
                     got.learn_dropped);
        end else begin
          want = expected_results.pop_front();
          if (got.forward_mask  !== want.forward_mask ||
              got.flooded       !== want.flooded      ||
              got.learned       !== want.learned      ||
              got.learn_dropped !== want.learn_dropped) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports)
              $display({"%0t: result %0d: expected mask %02h flood %b learn %b drop %b, ",
                        "got mask %02h flood %b learn %b drop %b"},
                       $realtime, checked_o, want.forward_mask, want.flooded, want.learned,
                       want.learn_dropped, got.forward_mask, got.flooded, got.learned,
                       got.learn_dropped);
          end
          checked_o++;
          flooded_o += want.flooded;
          learned_o += want.learned;
          dropped_o += want.learn_dropped;
        end
      end
      // The mask is only ever written while no frame is in flight.
      if (cfg_mon.valid && cfg_mon.ready) enable_mask = cfg_mon.data;
      if (frame_mon.valid && frame_mon.ready)
        expected_results.insert(expected_results.size(), forward_frame(frame_mon.data));
    end
    pending_o = expected_results.size();
  end

endmodule

/* dv/tb_mac_learning_forward_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mac_learning_forward_table: testbench of the MAC learning forwarding table
// Drives frame words and port enable mask writes, with random gaps on the
// frame side and random stalls on the result side. A short directed sequence
// covers self hits, moved stations, address extremes and floods with no port
// eligible; random phases with a station pool then fill the table and run on
// with it full. Checking is done by mlft_checker, instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_mac_learning_forward_table;

  localparam int CycleLimit  = 1500000;
  localparam int PoolSize    = 128;
  localparam int FirstSpan   = 40;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 200;
  localparam int SettleWait  = 80;

  // Fixed stations of the directed sequence.
  localparam logic [mlft_pkg::MacW-1:0] StaA    = 48'h02_00_00_00_00_0A;
  localparam logic [mlft_pkg::MacW-1:0] StaB    = 48'h02_00_00_00_00_0B;
  localparam logic [mlft_pkg::MacW-1:0] StaC    = 48'hA5_5A_C3_3C_0F_F0;
  localparam logic [mlft_pkg::MacW-1:0] StaD    = 48'h5A_A5_3C_C3_F0_0F;
  localparam logic [mlft_pkg::MacW-1:0] StaE    = 48'h80_00_00_00_00_01;
  localparam logic [mlft_pkg::MacW-1:0] StaF    = 48'h00_00_00_00_00_01;
  localparam logic [mlft_pkg::MacW-1:0] StaG    = 48'h80_00_00_00_00_00;
  localparam logic [mlft_pkg::MacW-1:0] StaH    = 48'h12_34_56_78_9A_BC;
  localparam logic [mlft_pkg::MacW-1:0] StaJ    = 48'hFE_DC_BA_98_76_54;
  localparam logic [mlft_pkg::MacW-1:0] MacOnes = '1;
  localparam logic [mlft_pkg::MacW-1:0] MacZero = '0;

  logic clk_i;
  logic rst_ni;

  mlft_frame_if  frame_ch ();
  mlft_result_if result_ch ();
  mlft_cfg_if    cfg_ch ();

  int fail_count;
  int pending_results;
  int checked_count;
  int flooded_count;
  int learned_count;
  int dropped_count;
  int cycle_count;
  int frames_sent;
  int mask_writes;
  bit steady_source;
  bit steady_sink;

  logic [mlft_pkg::MacW-1:0]  station_mac  [PoolSize];
  logic [mlft_pkg::PortW-1:0] station_home [PoolSize];

  mac_learning_forward_table u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  mlft_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_mon    (frame_ch),
    .result_mon   (result_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (checked_count),
    .flooded_o    (flooded_count),
    .learned_o    (learned_count),
    .dropped_o    (dropped_count)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit, well beyond the slowest correct run.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               pending_results);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [mlft_pkg::MacW-1:0] random_mac();
    return mlft_pkg::MacW'({$urandom(), $urandom()});
  endfunction

  function automatic mlft_pkg::frame_t make_frame(logic [mlft_pkg::MacW-1:0] src,
                                                  logic [mlft_pkg::MacW-1:0] dst,
                                                  logic [mlft_pkg::PortW-1:0] port);
    mlft_pkg::frame_t f;
    f.src_mac      = src;
    f.dst_mac      = dst;
    f.ingress_port = port;
    return f;
  endfunction

  // Mostly pool stations on their home port, with fresh addresses and
  // stations turning up on another port mixed in.
  function automatic mlft_pkg::frame_t random_frame(int src_span);
    mlft_pkg::frame_t f;
    int               pick;
    int               r;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, src_span - 1);
    if (r < 80) begin
      f.src_mac      = station_mac[pick];
      f.ingress_port = ($urandom_range(0, 3) != 0) ? station_home[pick] :
                       mlft_pkg::PortW'($urandom_range(0, mlft_pkg::NumPorts - 1));
    end else begin
      f.src_mac      = random_mac();
      f.ingress_port = mlft_pkg::PortW'($urandom_range(0, mlft_pkg::NumPorts - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 70)      f.dst_mac = station_mac[$urandom_range(0, PoolSize - 1)];
    else if (r < 80) f.dst_mac = MacOnes;
    else if (r < 86) f.dst_mac = f.src_mac;
    else             f.dst_mac = random_mac();
    return f;
  endfunction

  // Result side pacing: bursts of ready and stalls of random length.
  initial begin : sink_pacing
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady_sink) begin
        result_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) != 0) begin
        result_ch.ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        result_ch.ready <= 1'b0;
        hold = gap_len();
      end
    end
  end

  // Offers one frame word after a random gap and waits until it is taken.
  // Valid stays high into the next word when there is no gap.
  task automatic send_frame(input mlft_pkg::frame_t f);
    int gap;
    gap = steady_source ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      frame_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    frame_ch.valid <= 1'b1;
    frame_ch.data  <= f;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    frames_sent++;
  endtask

  // Stops offering frames until every outstanding result word has come.
  task automatic drain_frames();
    @(negedge clk_i);
    frame_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // Writes the port enable mask with the block idle.
  task automatic write_mask(input mlft_pkg::cfg_t mask);
    drain_frames();
    repeat (4) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= mask;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    mask_writes++;
  endtask

  initial begin
    int             span;
    mlft_pkg::cfg_t mask;

    rst_ni         = 1'b0;
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    steady_source  = 1'b0;
    steady_sink    = 1'b0;
    frames_sent    = 0;
    mask_writes    = 0;

    // Station pool, with both address extremes at the top.
    for (int i = 0; i < PoolSize; i++) begin
      station_mac[i]  = random_mac();
      station_home[i] = mlft_pkg::PortW'($urandom_range(0, mlft_pkg::NumPorts - 1));
    end
    station_mac[PoolSize - 2] = MacOnes;
    station_mac[PoolSize - 1] = MacZero;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sequence with every port enabled.
    write_mask(8'hFF);
    send_frame(make_frame(StaA, StaA, 3'd0));       // learns, then hits itself
    send_frame(make_frame(StaB, StaA, 3'd7));       // hit on another port
    send_frame(make_frame(StaA, StaB, 3'd5));       // known station on a new port
    send_frame(make_frame(StaA, StaA, 3'd5));       // old port is kept
    send_frame(make_frame(StaC, StaD, 3'd3));       // unknown destination floods
    send_frame(make_frame(MacOnes, MacZero, 3'd7));
    send_frame(make_frame(MacZero, MacOnes, 3'd2));
    send_frame(make_frame(StaB, StaB, 3'd7));       // hit on the ingress port
    send_frame(make_frame(StaD, StaC, 3'd6));
    send_frame(make_frame(StaE, MacZero, 3'd1));

    // No port eligible for flooding; hits still forward.
    write_mask(8'h00);
    send_frame(make_frame(StaF, StaG, 3'd4));
    send_frame(make_frame(StaA, StaC, 3'd0));
    send_frame(make_frame(StaG, StaF, 3'd0));

    write_mask(8'h5A);
    send_frame(make_frame(StaH, StaJ, 3'd1));
    send_frame(make_frame(StaJ, StaH, 3'd6));

    // Random phases: the first two keep to part of the pool so the table
    // stays below full for a while; later ones fill it and run on full.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       mask = 8'h00;
        1:       mask = 8'hFF;
        3:       mask = 8'h01;
        4:       mask = 8'h80;
        6:       mask = 8'h7E;
        7:       mask = 8'hFF;
        default: mask = mlft_pkg::cfg_t'($urandom());
      endcase
      write_mask(mask);
      steady_source = (p == 3);
      steady_sink   = (p == 3 || p == 6);
      span = (p < 2) ? FirstSpan : PoolSize;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) == 0) drain_frames();
        send_frame(random_frame(span));
      end
    end

    drain_frames();
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d frames under %0d port enable settings; %0d results checked.",
             frames_sent, mask_writes, checked_count);
    $display("Results seen: %0d flooded, %0d learned, %0d learning dropped %s",
             flooded_count, learned_count, dropped_count, "with the table full.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* mac_learning_forward_table.f */
design/mlft_pkg.sv
design/mlft_if.sv
design/mlft_ram.sv
design/mac_learning_forward_table.sv
dv/mlft_checker.sv
dv/tb_mac_learning_forward_table.sv
